@@ design/fss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg: shared definitions for the first substring match block
// Sizes, register indexes, the cell control group and the pattern byte select.
// ----------------------------------------------------------------------------
package fss_pkg;

    // text and pattern limits
    localparam int MAX_TEXT    = 128;
    localparam int PATTERN_MAX = 16;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 5;
    localparam int IDX_W   = 7;
    localparam int SEL_W   = 4;
    localparam int CFG_W   = 64;
    localparam int PAT_W   = 2 * CFG_W;
    localparam int OUT_W   = 16;

    // byte counter holds 0 .. MAX_TEXT
    localparam int POS_W   = $clog2(MAX_TEXT + 1);

    // width for start index arithmetic
    localparam int CALC_W0 = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int CALC_W  = (CALC_W0 > IDX_W) ? CALC_W0 : IDX_W;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_PATTERN_LOWER = 2'd0,
        REG_PATTERN_UPPER = 2'd1,
        REG_PATTERN_LEN   = 2'd2
    } cfg_reg_t;

    // control shared by every cell of the window
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // byte sel of the 16-byte pattern, byte 0 in the lowest bits
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PAT_W-1:0] pat,
        input logic [SEL_W-1:0] sel
    );
        logic [BYTE_W-1:0] b;
        b = pat[sel*BYTE_W +: BYTE_W];
        return b;
    endfunction

endpackage
`default_nettype wire

@@ design/fss_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fss_cell: one window position
// Holds one text byte, passes it on to the next cell and checks the incoming
// byte against the pattern byte that lines up with this position.
// ----------------------------------------------------------------------------
module fss_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire fss_pkg::cell_ctrl_t       ctrl,
    input  wire logic [7:0]                d_in,
    input  wire logic [7:0]                exp_byte,
    input  wire logic                      use_cell,
    output logic [7:0]                     q,
    output logic                           hit
);
    import fss_pkg::*;

    logic [BYTE_W-1:0] data_reg;

    // window byte, cleared at the end of each text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            data_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

    // compare on the byte that enters this cell now
    assign hit = !use_cell || (d_in == exp_byte);

endmodule
`default_nettype wire

@@ design/fss_cell_chain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fss_cell_chain: row of window cells
// Newest byte enters cell 0; cell k lines up with pattern byte len-1-k, and
// the hits of all cells combine into one window match.
// ----------------------------------------------------------------------------
module fss_cell_chain (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire fss_pkg::cell_ctrl_t       ctrl,
    input  wire logic [7:0]                text_byte,
    input  wire logic [127:0]              pattern,
    input  wire logic [4:0]                len_used,
    output logic                           all_hit
);
    import fss_pkg::*;

    logic [BYTE_W-1:0]      cell_q   [PATTERN_MAX];
    logic [BYTE_W-1:0]      cell_d   [PATTERN_MAX];
    logic [BYTE_W-1:0]      cell_exp [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_use;
    logic [PATTERN_MAX-1:0] cell_hit;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [LEN_W-1:0] sel_full;

            // pattern byte for this position
            assign sel_full    = len_used - LEN_W'(1) - LEN_W'(k);
            assign cell_use[k] = LEN_W'(k) < len_used;
            assign cell_exp[k] = pattern_byte(pattern, sel_full[SEL_W-1:0]);

            // data handed on from the neighbor
            if (k == 0)
            begin : g_head
                assign cell_d[k] = text_byte;
            end
            else
            begin : g_body
                assign cell_d[k] = cell_q[k-1];
            end

            fss_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .d_in     (cell_d[k]),
                .exp_byte (cell_exp[k]),
                .use_cell (cell_use[k]),
                .q        (cell_q[k]),
                .hit      (cell_hit[k])
            );
        end
    endgenerate

    // the last cell's byte drops off the window
    assign all_hit = &cell_hit;

endmodule
`default_nettype wire

@@ design/first_substring_match.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_substring_match: streaming first substring search
// Compares a window of recent text bytes with a configured pattern and
// reports the first occurrence at the end of each text.
// ----------------------------------------------------------------------------
// Usage
//   cfg_we/cfg_index/cfg_data write the pattern registers: index 0 pattern
//   bytes 0..7, index 1 bytes 8..15, index 2 the pattern length (0..16, larger values capped at 16).
//   Write them only while no text is in flight.
//   s_axis carries the text one byte per word; s_axis_tlast marks the final
//   byte. Only the final byte produces a result word on m_axis.
//   One byte is taken per cycle while the input is not stalled; the row of
//   window cells shifts and compares in the same cycle. The result word shows
//   in the cycle after the final byte is accepted.
//   The result sits in an output register; while it waits for m_axis_tready
//   the input stalls, otherwise a new text may start in the very next cycle.
//   Reset clears the window, the counters and the pattern registers; all
//   text state also clears after each final byte.
//   Bytes past MAX_TEXT are dropped and set the overflow bit of the result.
// ----------------------------------------------------------------------------
module first_substring_match (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write port
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    // text input
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // text_byte
    input  wire logic         s_axis_tlast,   // last_byte
    // result output
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata    // found, first_index[6:0], overflow, zeros
);
    import fss_pkg::*;

    // configuration registers
    logic [CFG_W-1:0]  pat_lower_reg;
    logic [CFG_W-1:0]  pat_upper_reg;
    logic [LEN_W-1:0]  pat_len_reg;

    // text state
    logic [POS_W-1:0]  pos_reg;
    logic              seen_reg;
    logic [IDX_W-1:0]  start_reg;
    logic              exceeded_reg;

    // result register
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic              accept;
    logic              in_range;
    cell_ctrl_t        cell_ctrl;
    logic [LEN_W-1:0]  len_used;
    logic              all_hit;
    logic [POS_W-1:0]  pos_inc;
    logic [CALC_W-1:0] pos_ext;
    logic [CALC_W-1:0] len_ext;
    logic [CALC_W-1:0] start_calc;
    logic              hit_now;
    logic              seen_next;
    logic [IDX_W-1:0]  start_next;
    logic              exceeded_next;
    logic              found_res;
    logic [IDX_W-1:0]  index_res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lower_reg <= '0;
            pat_upper_reg <= '0;
            pat_len_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LOWER: pat_lower_reg <= cfg_data;
                REG_PATTERN_UPPER: pat_upper_reg <= cfg_data;
                REG_PATTERN_LEN:   pat_len_reg   <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // pattern length capped at the window size
    assign len_used = (pat_len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : pat_len_reg;

    // handshake and cell control
    assign s_axis_tready   = !out_valid_reg || m_axis_tready;
    assign accept          = s_axis_tvalid && s_axis_tready;
    assign in_range        = pos_reg < POS_W'(MAX_TEXT);
    assign cell_ctrl.shift = accept && in_range;
    assign cell_ctrl.clear = accept && s_axis_tlast;

    fss_cell_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .text_byte (s_axis_tdata),
        .pattern   ({pat_upper_reg, pat_lower_reg}),
        .len_used  (len_used),
        .all_hit   (all_hit)
    );

    // first match tracking
    assign pos_inc    = pos_reg + POS_W'(1);
    assign pos_ext    = CALC_W'(pos_inc);
    assign len_ext    = CALC_W'(len_used);
    assign start_calc = pos_ext - len_ext;
    assign hit_now    = cell_ctrl.shift && (len_used != '0) && (pos_ext >= len_ext)
                        && all_hit && !seen_reg;
    assign seen_next     = seen_reg || hit_now;
    assign start_next    = hit_now ? start_calc[IDX_W-1:0] : start_reg;
    assign exceeded_next = exceeded_reg || (accept && !in_range);

    // result fields
    assign found_res = (len_used == '0) ? 1'b1 : seen_next;
    assign index_res = ((len_used == '0) || !seen_next) ? '0 : start_next;

    // text state update, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            seen_reg     <= 1'b0;
            start_reg    <= '0;
            exceeded_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                pos_reg      <= '0;
                seen_reg     <= 1'b0;
                start_reg    <= '0;
                exceeded_reg <= 1'b0;
            end
            else
            begin
                if (in_range)
                begin
                    pos_reg <= pos_inc;
                end
                seen_reg     <= seen_next;
                start_reg    <= start_next;
                exceeded_reg <= exceeded_next;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && s_axis_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tlast)
        begin
            out_data_reg <= {{(OUT_W - IDX_W - 2){1'b0}}, exceeded_next, index_res,
                             found_res};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // input is never blocked while no result is pending
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // a final byte always yields a result in the next cycle
    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("no result after final byte");

    // not found reports index zero
    a_index_zero_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[7:1] == '0))
        else $error("nonzero index without a match");

    // byte counter never passes the text limit
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_TEXT))
        else $error("byte counter beyond text limit");
`endif

endmodule
`default_nettype wire
